/* hw/rtl/sqtq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqtq_pkg
// Shared constants, command and status types of the query token quoter.
// ----------------------------------------------------------------------------
package sqtq_pkg;

  localparam int PREFIX_BYTES = 16;
  localparam int PFX_CNT_W    = $clog2(PREFIX_BYTES + 2);
  localparam int PFX_IDX_W    = (PREFIX_BYTES > 1) ? $clog2(PREFIX_BYTES) : 1;

  localparam logic [7:0] MAX_TOKENS_RST = 8'd32;
  localparam logic [7:0] CHR_QUOTE      = 8'h22;
  localparam logic [7:0] CHR_STAR       = 8'h2A;
  localparam logic [7:0] CHR_NUL        = 8'h00;
  localparam logic [2:0] SEP_LAST       = 3'd4;

  typedef enum logic [2:0] {
    SEL_QUOTE,
    SEL_STAR,
    SEL_TERM,
    SEL_SEP,
    SEL_PFX,
    SEL_BYTE
  } osel_e;

  typedef struct packed {
    logic  capture;
    logic  load_out;
    osel_e osel;
    logic  upd_blank;
    logic  start_tok;
    logic  open_tok;
    logic  store_pfx;
    logic  pfx_adv;
    logic  sep_adv;
    logic  byte_done;
    logic  clear_expr;
  } ctrl_cmd_t;

  typedef struct packed {
    logic eot;
    logic blank;
    logic idx;
    logic byte_quote;
    logic in_tok;
    logic kept;
    logic any_tokens;
    logic at_limit;
    logic cp_ge2;
    logic pfx_more;
    logic pfx_quote;
    logic sep_last;
    logic out_free;
  } dp_stat_t;

  // " AND " separator
  function automatic logic [7:0] sep_char(input logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd1:    c = 8'h41;
      3'd2:    c = 8'h4E;
      3'd3:    c = 8'h44;
      default: c = 8'h20;
    endcase
    return c;
  endfunction

endpackage

/* hw/rtl/sqtq_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqtq_ctrl
// Controller state machine: decodes each input byte and sequences the
// output bytes: separators, quotes, stored prefix, the byte, star, terminator.
// ----------------------------------------------------------------------------
module sqtq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sqtq_pkg::dp_stat_t  stat_i,
  output sqtq_pkg::ctrl_cmd_t cmd_o
);
  import sqtq_pkg::*;

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_DECIDE  = 4'd1;
  localparam logic [3:0] ST_CLOSE   = 4'd2;
  localparam logic [3:0] ST_STAR    = 4'd3;
  localparam logic [3:0] ST_TERM    = 4'd4;
  localparam logic [3:0] ST_SEP     = 4'd5;
  localparam logic [3:0] ST_QOPEN   = 4'd6;
  localparam logic [3:0] ST_PFX     = 4'd7;
  localparam logic [3:0] ST_PFXDBL  = 4'd8;
  localparam logic [3:0] ST_BYTE    = 4'd9;
  localparam logic [3:0] ST_BYTEDBL = 4'd10;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    cmd_o   = '0;
    cmd_o.osel = SEL_QUOTE;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (stat_i.eot) begin
          state_d = (stat_i.in_tok && stat_i.kept) ? ST_CLOSE : ST_STAR;
        end else if (stat_i.at_limit && !(stat_i.in_tok && stat_i.kept)) begin
          state_d = ST_IDLE;
        end else if (stat_i.blank) begin
          cmd_o.upd_blank = 1'b1;
          state_d = (stat_i.in_tok && stat_i.kept) ? ST_CLOSE : ST_IDLE;
        end else begin
          cmd_o.start_tok = 1'b1;
          if (stat_i.kept) begin
            state_d = ST_BYTE;
          end else if (stat_i.idx) begin
            cmd_o.open_tok = 1'b1;
            state_d = stat_i.any_tokens ? ST_SEP : ST_QOPEN;
          end else begin
            cmd_o.store_pfx = 1'b1;
            state_d = ST_IDLE;
          end
        end
      end
      ST_CLOSE: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.osel = SEL_QUOTE;
          state_d = stat_i.eot ? ST_STAR : ST_IDLE;
        end
      end
      ST_STAR: begin
        if (stat_i.any_tokens && stat_i.cp_ge2) begin
          if (stat_i.out_free) begin
            cmd_o.load_out = 1'b1;
            cmd_o.osel = SEL_STAR;
            state_d = ST_TERM;
          end
        end else begin
          state_d = ST_TERM;
        end
      end
      ST_TERM: begin
        if (stat_i.out_free) begin
          cmd_o.load_out   = 1'b1;
          cmd_o.osel       = SEL_TERM;
          cmd_o.clear_expr = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_SEP: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.osel     = SEL_SEP;
          cmd_o.sep_adv  = 1'b1;
          if (stat_i.sep_last) begin
            state_d = ST_QOPEN;
          end
        end
      end
      ST_QOPEN: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.osel = SEL_QUOTE;
          state_d = ST_PFX;
        end
      end
      ST_PFX: begin
        if (!stat_i.pfx_more) begin
          state_d = ST_BYTE;
        end else if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.osel     = SEL_PFX;
          cmd_o.pfx_adv  = 1'b1;
          state_d = stat_i.pfx_quote ? ST_PFXDBL : ST_PFX;
        end
      end
      ST_PFXDBL: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.osel = SEL_QUOTE;
          state_d = ST_PFX;
        end
      end
      ST_BYTE: begin
        if (stat_i.out_free) begin
          cmd_o.load_out  = 1'b1;
          cmd_o.osel      = SEL_BYTE;
          cmd_o.byte_done = 1'b1;
          state_d = stat_i.byte_quote ? ST_BYTEDBL : ST_IDLE;
        end
      end
      ST_BYTEDBL: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.osel = SEL_QUOTE;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/sqtq_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqtq_dp
// Datapath: token state, prefix store, limit register and output register.
// ----------------------------------------------------------------------------
module sqtq_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [7:0]          in_byte_i,
  input  logic                in_eot_i,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_wdata_i,
  input  sqtq_pkg::ctrl_cmd_t cmd_i,
  output sqtq_pkg::dp_stat_t  stat_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          out_byte_o,
  output logic                out_last_o,
  output logic                out_noq_o,
  output logic                out_ovf_o
);
  import sqtq_pkg::*;

  localparam logic [PFX_CNT_W-1:0] PB = PFX_CNT_W'(PREFIX_BYTES);

  logic [7:0]           byte_q;
  logic                 eot_q;
  logic [7:0]           pfx_mem [PREFIX_BYTES];
  logic [PFX_CNT_W-1:0] cnt_q, rd_q, rd_d, pfx_n;
  logic                 inside_q, kept_q, ovf_q;
  logic [7:0]           tokens_q, max_tokens_q;
  logic [1:0]           cp_q;
  logic [2:0]           sep_q;
  logic [7:0]           pfx_byte, obyte_d, pfx_rd_q;
  logic                 oval_q, olast_q, onoq_q, oovf_q;
  logic [7:0]           obyte_q;

  function automatic logic [1:0] cp_add(input logic [1:0] n, input logic [7:0] b);
    logic [1:0] r;
    r = n;
    if ((b[7:6] != 2'b10) && (n != 2'd3)) begin
      r = n + 2'd1;
    end
    return r;
  endfunction

  // read address runs one step ahead so the read data is registered
  always_comb begin
    rd_d = rd_q;
    if (cmd_i.open_tok) begin
      rd_d = '0;
    end else if (cmd_i.pfx_adv) begin
      rd_d = rd_q + 1'b1;
    end
  end

  assign pfx_n    = (cnt_q > PB) ? PB : cnt_q;
  assign pfx_byte = pfx_rd_q;

  always_comb begin
    stat_o.eot        = eot_q;
    stat_o.blank      = (byte_q == 8'h20) || (byte_q == 8'h09) || (byte_q == 8'h0A) ||
                        (byte_q == 8'h0D) || (byte_q == 8'h0C) || (byte_q == 8'h0B);
    stat_o.idx        = byte_q[7] || ((byte_q >= 8'h30) && (byte_q <= 8'h39)) ||
                        ((byte_q >= 8'h41) && (byte_q <= 8'h5A)) ||
                        ((byte_q >= 8'h61) && (byte_q <= 8'h7A));
    stat_o.byte_quote = (byte_q == CHR_QUOTE);
    stat_o.in_tok     = inside_q;
    stat_o.kept       = kept_q;
    stat_o.any_tokens = (tokens_q != 8'd0);
    stat_o.at_limit   = (tokens_q >= max_tokens_q);
    stat_o.cp_ge2     = cp_q[1];
    stat_o.pfx_more   = (rd_q < pfx_n);
    stat_o.pfx_quote  = (pfx_byte == CHR_QUOTE);
    stat_o.sep_last   = (sep_q == SEP_LAST);
    stat_o.out_free   = !oval_q || out_ready_i;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      byte_q <= in_byte_i;
    end
    if (cmd_i.store_pfx && (cnt_q < PB)) begin
      pfx_mem[cnt_q[PFX_IDX_W-1:0]] <= byte_q;
    end
    pfx_rd_q <= pfx_mem[rd_d[PFX_IDX_W-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_tokens_q <= MAX_TOKENS_RST;
    end else if (cfg_we_i) begin
      max_tokens_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eot_q    <= 1'b0;
      cnt_q    <= '0;
      rd_q     <= '0;
      inside_q <= 1'b0;
      kept_q   <= 1'b0;
      ovf_q    <= 1'b0;
      tokens_q <= '0;
      cp_q     <= '0;
      sep_q    <= '0;
    end else begin
      rd_q <= rd_d;
      if (cmd_i.capture) begin
        eot_q <= in_eot_i;
      end
      if (cmd_i.clear_expr) begin
        cnt_q    <= '0;
        inside_q <= 1'b0;
        kept_q   <= 1'b0;
        ovf_q    <= 1'b0;
        tokens_q <= '0;
        cp_q     <= '0;
      end
      if (cmd_i.upd_blank) begin
        inside_q <= 1'b0;
        kept_q   <= 1'b0;
        cnt_q    <= '0;
      end
      if (cmd_i.start_tok) begin
        inside_q <= 1'b1;
      end
      if (cmd_i.store_pfx && (cnt_q <= PB)) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.open_tok) begin
        if (cnt_q > PB) begin
          ovf_q <= 1'b1;
        end
        cp_q  <= '0;
        sep_q <= '0;
      end
      if (cmd_i.sep_adv) begin
        sep_q <= sep_q + 3'd1;
      end
      if (cmd_i.pfx_adv) begin
        cp_q <= cp_add(cp_q, pfx_byte);
      end
      if (cmd_i.byte_done) begin
        cp_q <= cp_add(cp_q, byte_q);
        if (!kept_q) begin
          tokens_q <= tokens_q + 8'd1;
          kept_q   <= 1'b1;
          cnt_q    <= '0;
        end
      end
    end
  end

  always_comb begin
    case (cmd_i.osel)
      SEL_QUOTE: obyte_d = CHR_QUOTE;
      SEL_STAR:  obyte_d = CHR_STAR;
      SEL_TERM:  obyte_d = CHR_NUL;
      SEL_SEP:   obyte_d = sep_char(sep_q);
      SEL_PFX:   obyte_d = pfx_byte;
      SEL_BYTE:  obyte_d = byte_q;
      default:   obyte_d = CHR_NUL;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oval_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      oval_q <= 1'b1;
    end else if (out_ready_i) begin
      oval_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      obyte_q <= obyte_d;
      olast_q <= (cmd_i.osel == SEL_TERM);
      onoq_q  <= (cmd_i.osel == SEL_TERM) && (tokens_q == 8'd0);
      oovf_q  <= ovf_q;
    end
  end

  assign out_valid_o = oval_q;
  assign out_byte_o  = obyte_q;
  assign out_last_o  = olast_q;
  assign out_noq_o   = onoq_q;
  assign out_ovf_o   = oovf_q;

endmodule

/* hw/rtl/search_query_token_quoter_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// search_query_token_quoter_unit
// Quotes whitespace-split query tokens and joins them with " AND " into a
// full-text query expression, one byte per output transaction.
//
// channel   dir  tdata            tlast        tuser
// s_axis    in   text_byte        end_of_text  -
// m_axis    out  out_byte         expr_last    no_query, prefix_overflow
// cfg       in   max_tokens (write enable + data)
//
// The next input byte is accepted only once the sequencer has loaded every
// output byte of the last one; opening a token gives up to 39 output bytes.
// An output byte waits while m_axis_tready is low and stalls the sequencer.
// The next input is taken while the last output byte still waits in m_axis.
// Reset is asynchronous, active low; max_tokens returns to 32.
// ----------------------------------------------------------------------------
module search_query_token_quoter_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] text_byte
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast,
  output logic [1:0] m_axis_tuser,   // [0] no_query, [1] prefix_overflow
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i
);
  import sqtq_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  logic      noq, ovf;

  sqtq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  sqtq_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_byte_i   (s_axis_tdata),
    .in_eot_i    (s_axis_tlast),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_noq_o   (noq),
    .out_ovf_o   (ovf)
  );

  assign m_axis_tuser = {ovf, noq};

endmodule

/* test/query_expr_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// query_expr_checker
// Watches the text and expression streams of the query token quoter. It
// rebuilds the expected expression bytes from every accepted text transaction
// and compares each accepted output transaction with the oldest expected
// byte, field by field.
// ----------------------------------------------------------------------------
module query_expr_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       text_valid_i,
  input  logic       text_ready_i,
  input  logic [7:0] text_data_i,
  input  logic       text_last_i,
  input  logic       expr_valid_i,
  input  logic       expr_ready_i,
  input  logic [7:0] expr_data_i,
  input  logic       expr_last_i,
  input  logic [1:0] expr_user_i,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  output int         mismatches_o,
  output int         pending_o
);
  import sqtq_pkg::*;

  localparam logic [39:0] AND_SEP = " AND ";

  typedef struct packed {
    logic [7:0] out_byte;
    logic       expr_last;
    logic       no_query;
    logic       prefix_overflow;
  } expr_byte_t;

  expr_byte_t  expected_bytes[$];
  logic [7:0]  max_tokens;
  logic [7:0]  pfx_mem[PREFIX_BYTES];
  int unsigned pfx_len;
  logic        in_word;
  logic        word_kept;
  logic [7:0]  words_done;
  logic [1:0]  cp_seen;
  logic        ovf_seen;
  int          fails;

  assign mismatches_o = fails;

  function automatic logic blank_byte(input logic [7:0] b);
    return (b == 8'h20) || (b == 8'h09) || (b == 8'h0A) || (b == 8'h0D) ||
           (b == 8'h0C) || (b == 8'h0B);
  endfunction

  function automatic logic word_byte(input logic [7:0] b);
    return (b >= 8'h80) || (b >= 8'h30 && b <= 8'h39) ||
           (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
  endfunction

  // continuation bytes of a multi-byte sequence are not code points
  function automatic logic [1:0] cp_count(input logic [1:0] n, input logic [7:0] b);
    if (b[7:6] != 2'b10 && n != 2'd3) begin
      return n + 2'd1;
    end
    return n;
  endfunction

  function automatic void push_expr(input logic [7:0] b, input logic last, input logic noq);
    expr_byte_t e;
    e.out_byte        = b;
    e.expr_last       = last;
    e.no_query        = noq;
    e.prefix_overflow = ovf_seen;
    expected_bytes.push_back(e);
  endfunction

  function automatic void push_quoted(input logic [7:0] b);
    push_expr(b, 1'b0, 1'b0);
    if (b == CHR_QUOTE) begin
      push_expr(CHR_QUOTE, 1'b0, 1'b0);
    end
  endfunction

  function automatic void clear_expr_state();
    pfx_len    = 0;
    in_word    = 1'b0;
    word_kept  = 1'b0;
    words_done = 8'd0;
    cp_seen    = 2'd0;
    ovf_seen   = 1'b0;
  endfunction

  function automatic void quote_text(input logic [7:0] b, input logic eot);
    int unsigned n;
    int          i;
    if (eot) begin
      if (in_word && word_kept) begin
        push_expr(CHR_QUOTE, 1'b0, 1'b0);
      end
      if (words_done != 8'd0) begin
        if (cp_seen >= 2'd2) begin
          push_expr(CHR_STAR, 1'b0, 1'b0);
        end
        push_expr(CHR_NUL, 1'b1, 1'b0);
      end else begin
        push_expr(CHR_NUL, 1'b1, 1'b1);
      end
      clear_expr_state();
      return;
    end
    // token limit reached and nothing open
    if (words_done >= max_tokens && !(in_word && word_kept)) begin
      return;
    end
    if (blank_byte(b)) begin
      if (in_word && word_kept) begin
        push_expr(CHR_QUOTE, 1'b0, 1'b0);
      end
      in_word   = 1'b0;
      word_kept = 1'b0;
      pfx_len   = 0;
      return;
    end
    if (!in_word) begin
      in_word   = 1'b1;
      word_kept = 1'b0;
      pfx_len   = 0;
    end
    if (word_kept) begin
      push_quoted(b);
      cp_seen = cp_count(cp_seen, b);
      return;
    end
    if (word_byte(b)) begin
      if (pfx_len > PREFIX_BYTES) begin
        ovf_seen = 1'b1;
      end
      if (words_done != 8'd0) begin
        for (i = 4; i >= 0; i--) begin
          push_expr(AND_SEP[i*8 +: 8], 1'b0, 1'b0);
        end
      end
      push_expr(CHR_QUOTE, 1'b0, 1'b0);
      n       = (pfx_len > PREFIX_BYTES) ? PREFIX_BYTES : pfx_len;
      cp_seen = 2'd0;
      for (i = 0; i < n; i++) begin
        push_quoted(pfx_mem[i[PFX_IDX_W-1:0]]);
        cp_seen = cp_count(cp_seen, pfx_mem[i[PFX_IDX_W-1:0]]);
      end
      push_expr(b, 1'b0, 1'b0);
      cp_seen    = cp_count(cp_seen, b);
      words_done = words_done + 8'd1;
      word_kept  = 1'b1;
      pfx_len    = 0;
      return;
    end
    if (pfx_len < PREFIX_BYTES) begin
      pfx_mem[pfx_len[PFX_IDX_W-1:0]] = b;
    end
    if (pfx_len <= PREFIX_BYTES) begin
      pfx_len++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    expr_byte_t want;
    if (!rst_ni) begin
      expected_bytes.delete();
      clear_expr_state();
      max_tokens = MAX_TOKENS_RST;
      fails      = 0;
      pending_o <= 0;
    end else begin
      if (expr_valid_i && expr_ready_i) begin
        if (expected_bytes.size() == 0) begin
          $error("unexpected output transaction: out_byte %02h", expr_data_i);
          fails++;
        end else begin
          want = expected_bytes.pop_front();
          if (expr_data_i !== want.out_byte) begin
            $error("out_byte: expected %02h, got %02h", want.out_byte, expr_data_i);
            fails++;
          end
          if (expr_last_i !== want.expr_last) begin
            $error("expr_last: expected %0b, got %0b", want.expr_last, expr_last_i);
            fails++;
          end
          if (expr_user_i[0] !== want.no_query) begin
            $error("no_query: expected %0b, got %0b", want.no_query, expr_user_i[0]);
            fails++;
          end
          if (expr_user_i[1] !== want.prefix_overflow) begin
            $error("prefix_overflow: expected %0b, got %0b", want.prefix_overflow,
                   expr_user_i[1]);
            fails++;
          end
        end
      end
      if (text_valid_i && text_ready_i) begin
        quote_text(text_data_i, text_last_i);
      end
      if (cfg_we_i) begin
        max_tokens = cfg_wdata_i;
      end
      pending_o <= expected_bytes.size();
    end
  end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives segmented query text into the query token quoter: a directed string
// with quotes, multi-byte characters, a prefix longer than the buffer and a
// string with no indexable token, then random strings under several token
// limits and stall patterns. A checker beside the block predicts and
// compares every output transaction.
// ----------------------------------------------------------------------------
module tb_top;
  import sqtq_pkg::*;

  localparam int          HALF_PERIOD       = 6;
  localparam int          RESET_CYCLES      = 10;
  localparam int          SETTLE_CYCLES     = 16;
  localparam int          ITEMS_PER_SEGMENT = 32;
  localparam int          SEGMENTS          = 6;
  localparam int unsigned CYCLE_LIMIT       = 400000;
  localparam logic [47:0] BLANKS            = {8'h20, 8'h09, 8'h0A, 8'h0D, 8'h0C, 8'h0B};

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  logic [1:0]  m_axis_tuser;
  logic        cfg_we_i      = 1'b0;
  logic [7:0]  cfg_wdata_i   = 8'h00;

  int          tx_idle_pct   = 14;
  int          rx_idle_pct   = 48;
  int unsigned items_sent    = 0;
  int unsigned cycles        = 0;
  int          mismatches;
  int          pending;

  search_query_token_quoter_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  query_expr_checker u_expr_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .text_valid_i(s_axis_tvalid),
    .text_ready_i(s_axis_tready),
    .text_data_i (s_axis_tdata),
    .text_last_i (s_axis_tlast),
    .expr_valid_i(m_axis_tvalid),
    .expr_ready_i(m_axis_tready),
    .expr_data_i (m_axis_tdata),
    .expr_last_i (m_axis_tlast),
    .expr_user_i (m_axis_tuser),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .mismatches_o(mismatches),
    .pending_o   (pending)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_text(input logic [7:0] b, input logic eot);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eot;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_max_tokens(input logic [7:0] v);
    cfg_wdata_i <= v;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic [7:0] blank_char();
    int sel;
    sel = $urandom_range(5);
    return BLANKS[sel*8 +: 8];
  endfunction

  // neither whitespace nor indexable
  function automatic logic [7:0] punct_char();
    logic [7:0] b;
    case ($urandom_range(5))
      0: b = CHR_QUOTE;
      1: b = 8'($urandom_range(8'h21, 8'h2F));
      2: b = 8'($urandom_range(8'h3A, 8'h40));
      3: b = 8'($urandom_range(8'h5B, 8'h60));
      4: b = 8'($urandom_range(8'h7B, 8'h7F));
      default: b = $urandom_range(1) ? 8'($urandom_range(8'h00, 8'h08))
                                     : 8'($urandom_range(8'h0E, 8'h1F));
    endcase
    return b;
  endfunction

  task automatic send_word_char();
    case ($urandom_range(5))
      0: send_text(8'($urandom_range(8'h30, 8'h39)), 1'b0);
      1: send_text($urandom_range(1) ? 8'($urandom_range(8'h41, 8'h5A))
                                     : 8'($urandom_range(8'h61, 8'h7A)), 1'b0);
      2: begin
        send_text(8'($urandom_range(8'hC2, 8'hDF)), 1'b0);
        send_text(8'($urandom_range(8'h80, 8'hBF)), 1'b0);
      end
      3: begin
        send_text(8'($urandom_range(8'hE0, 8'hEF)), 1'b0);
        repeat (2) send_text(8'($urandom_range(8'h80, 8'hBF)), 1'b0);
      end
      4: send_text(punct_char(), 1'b0);
      default: send_text(8'($urandom_range(8'h80, 8'hFF)), 1'b0);
    endcase
  endtask

  task automatic send_word();
    int unsigned pfx_n;
    pfx_n = ($urandom_range(7) == 0) ? $urandom_range(PREFIX_BYTES - 2, PREFIX_BYTES + 3)
                                     : $urandom_range(0, 2);
    repeat (pfx_n) send_text(punct_char(), 1'b0);
    // some tokens stay punctuation only
    if ($urandom_range(5) != 0) begin
      repeat ($urandom_range(1, 4)) send_word_char();
    end
  endtask

  task automatic send_query();
    int unsigned n_words;
    int unsigned w;
    if ($urandom_range(4) == 0) begin
      repeat ($urandom_range(1, 10)) send_text(8'($urandom_range(255)), 1'b0);
    end else begin
      n_words = $urandom_range(1, 4);
      if ($urandom_range(3) == 0) begin
        send_text(blank_char(), 1'b0);
      end
      for (w = 0; w < n_words; w++) begin
        send_word();
        if (w + 1 < n_words || $urandom_range(1)) begin
          repeat ($urandom_range(1, 2)) send_text(blank_char(), 1'b0);
        end
      end
    end
    send_text(8'($urandom_range(255)), 1'b1);
  endtask

  initial begin
    logic [7:0]  tok_limit;
    int          seg;
    int unsigned items_goal;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // quotes doubled, separator, overlong prefix, multi-byte tail
    send_text(8'h0B, 1'b0);
    send_text(CHR_QUOTE, 1'b0);
    send_text(8'h41, 1'b0);
    send_text(CHR_QUOTE, 1'b0);
    send_text(8'hFF, 1'b0);
    send_text(8'h0D, 1'b0);
    repeat (PREFIX_BYTES + 1) send_text(8'h7E, 1'b0);
    send_text(8'hC3, 1'b0);
    send_text(8'hA9, 1'b0);
    send_text(8'h00, 1'b1);
    // no indexable token
    send_text(8'h21, 1'b0);
    send_text(8'hFF, 1'b1);

    for (seg = 0; seg < SEGMENTS; seg++) begin
      case (seg / 2)
        0: begin
          tx_idle_pct = 14;
          rx_idle_pct = 48;
        end
        1: begin
          tx_idle_pct = 48;
          rx_idle_pct = 14;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      wait_idle();
      case (seg)
        0: tok_limit = 8'd1;
        1: tok_limit = 8'd255;
        2: tok_limit = 8'd2;
        3: tok_limit = 8'($urandom_range(3, 254));
        4: tok_limit = 8'd3;
        default: tok_limit = MAX_TOKENS_RST;
      endcase
      write_max_tokens(tok_limit);
      items_goal = items_sent + ITEMS_PER_SEGMENT;
      while (items_sent < items_goal) send_query();
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
